// ===== src/dhcpop_pkg.sv =====
`timescale 1ns / 1ps

package dhcpop_pkg;

    // option codes with special handling
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_END      = 8'd255;
    localparam logic [7:0] OPT_OVERLOAD = 8'd52;

    // cookie, most significant byte arrives first
    localparam logic [31:0] MAGIC_COOKIE = 32'h63825363;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // region codes
    localparam logic [1:0] REGION_OPTIONS = 2'd0;
    localparam logic [1:0] REGION_FILE    = 2'd1;
    localparam logic [1:0] REGION_SNAME   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] option_code;
        logic [7:0] byte_index;
        logic [7:0] value;
        logic       last_of_option;
        logic       end_found;
        logic       truncated;
        logic       magic_ok;
    } t_result;

    typedef struct packed {
        logic not_empty;
        logic room_two;
    } t_fifo_status;

endpackage

// ===== src/dhcpop_if.sv =====
`timescale 1ns / 1ps

interface dhcpop_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] region;
    logic [7:0] data_byte;
    logic       last_in_region;

    modport source (output valid, output region, output data_byte, output last_in_region,
                    input ready);
    modport sink   (input valid, input region, input data_byte, input last_in_region,
                    output ready);
endinterface

interface dhcpop_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] option_code;
    logic [7:0] byte_index;
    logic [7:0] value;
    logic       last_of_option;
    logic       end_found;
    logic       truncated;
    logic       magic_ok;

    modport source (output valid, output kind, output option_code, output byte_index,
                    output value, output last_of_option, output end_found,
                    output truncated, output magic_ok, input ready);
    modport sink   (input valid, input kind, input option_code, input byte_index,
                    input value, input last_of_option, input end_found,
                    input truncated, input magic_ok, output ready);
endinterface

// ===== src/dhcpop_out_fifo.sv =====
`timescale 1ns / 1ps

// Result queue: takes up to two results per cycle, hands out one.
module dhcpop_out_fifo
    import dhcpop_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_cnt,
    input  t_result                      i_data_a,
    input  t_result                      i_data_b,
    input  logic                         i_pop,
    output t_result                      o_head,
    output t_fifo_status                 o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   wr_b;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_b = ptr_inc(r_wr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case (i_push_cnt)
                2'd1:    r_wr <= wr_b;
                2'd2:    r_wr <= ptr_inc(wr_b);
                default: r_wr <= r_wr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_data_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_b] <= i_data_b;
        end
    end

    assign o_head             = r_mem[r_rd];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.room_two  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_level            = r_count;

endmodule

// ===== src/dhcp_option_parser.sv =====
`timescale 1ns / 1ps

// DHCP option parser. Feed the options region, then the file region, then the
// server-name region, one byte per request, with last_in_region on each
// region's final byte. The options region must open with the 63 82 53 63
// cookie; on a mismatch nothing is parsed. PAD is skipped, END skips the rest
// of its region, and the overload option (52) is consumed silently: bit 0 of
// its first data byte enables the file region, bit 1 the server-name region,
// effective for regions that have not yet started. Each option data byte comes
// out as a kind 0 result with its code and index; a zero-length option gives
// one kind 1 marker. The final byte of the server-name region adds a kind 2
// done result (end_found, truncated, magic_ok) and the parser returns to its
// reset state. Throughput is one byte per clock: the parse state is updated at
// the clock edge that takes the byte, and its results are written into a small
// output queue at that same edge. The input stalls only when that queue has fewer
// than two free slots, e.g. when the downstream side holds off.
module dhcp_option_parser
    import dhcpop_pkg::*;
#(
    parameter int FIFO_DEPTH = 4   // output queue entries, at least 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dhcpop_in_if.sink     i_in,
    dhcpop_out_if.source  o_out
);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_CODE,
        PH_LEN,
        PH_DATA,
        PH_SKIP
    } t_phase;

    // parse state
    t_phase      r_phase,       n_phase;
    logic [1:0]  r_magic_count, n_magic_count;
    logic        r_magic_good,  n_magic_good;
    logic [7:0]  r_code,        n_code;
    logic [7:0]  r_remain,      n_remain;
    logic [7:0]  r_pos,         n_pos;
    logic        r_file_en,     n_file_en;
    logic        r_sname_en,    n_sname_en;
    logic [7:0]  r_last_code,   n_last_code;
    logic        r_overrun,     n_overrun;

    logic        accept;
    logic        res_opt, res_done;   // option result / done result this byte
    t_result     opt_result, done_result;
    logic [7:0]  b;
    logic        next_on;

    logic [1:0]         push_cnt;
    t_result            fifo_head;
    t_fifo_status       fifo_status;
    logic [CNT_W-1:0]   fifo_level;

    assign b      = i_in.data_byte;
    assign accept = i_in.valid & i_in.ready;

    always_comb begin
        n_phase       = r_phase;
        n_magic_count = r_magic_count;
        n_magic_good  = r_magic_good;
        n_code        = r_code;
        n_remain      = r_remain;
        n_pos         = r_pos;
        n_file_en     = r_file_en;
        n_sname_en    = r_sname_en;
        n_last_code   = r_last_code;
        n_overrun     = r_overrun;
        next_on       = 1'b0;
        res_opt       = 1'b0;
        res_done      = 1'b0;
        opt_result    = '0;
        done_result   = '0;

        case (r_phase)
            PH_MAGIC: begin
                // compare against cookie byte r_magic_count, MSB first
                if (b != MAGIC_COOKIE[{~r_magic_count, 3'b000} +: 8]) begin
                    n_magic_good = 1'b0;
                end
                n_magic_count = r_magic_count + 2'd1;
                if (n_magic_count == 2'd0) begin
                    n_phase = n_magic_good ? PH_CODE : PH_SKIP;
                end else if (i_in.last_in_region) begin
                    n_magic_good = 1'b0;    // region ended inside cookie
                end
            end
            PH_CODE: begin
                n_last_code = b;
                if (b == OPT_END) begin
                    n_phase = PH_SKIP;
                end else if (b != OPT_PAD) begin
                    n_code  = b;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_remain = b;
                n_pos    = 8'd0;
                if (b == 8'd0) begin
                    if (r_code != OPT_OVERLOAD) begin
                        res_opt                   = 1'b1;
                        opt_result.kind           = KIND_EMPTY;
                        opt_result.option_code    = r_code;
                        opt_result.last_of_option = 1'b1;
                    end
                    n_phase = PH_CODE;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_code == OPT_OVERLOAD) begin
                    if (r_pos == 8'd0) begin
                        n_file_en  = b[0];
                        n_sname_en = b[1];
                    end
                end else begin
                    res_opt                   = 1'b1;
                    opt_result.kind           = KIND_DATA;
                    opt_result.option_code    = r_code;
                    opt_result.byte_index     = r_pos;
                    opt_result.value          = b;
                    opt_result.last_of_option = (r_remain == 8'd1);
                end
                n_pos    = r_pos + 8'd1;
                n_remain = r_remain - 8'd1;
                if (n_remain == 8'd0) begin
                    n_phase = PH_CODE;
                end
            end
            default: begin
            end
        endcase

        if (i_in.last_in_region) begin
            // region closed with an option half read
            if (n_phase == PH_LEN || n_phase == PH_DATA) begin
                n_overrun = 1'b1;
            end
            if (i_in.region[1]) begin
                // server-name region (or region code 3): report and restart
                res_done                = 1'b1;
                done_result.kind        = KIND_DONE;
                done_result.option_code = n_last_code;
                done_result.end_found   = (n_last_code == OPT_END);
                done_result.truncated   = n_overrun;
                done_result.magic_ok    = n_magic_good;
                n_phase       = PH_MAGIC;
                n_magic_count = 2'd0;
                n_magic_good  = 1'b1;
                n_code        = 8'd0;
                n_remain      = 8'd0;
                n_pos         = 8'd0;
                n_file_en     = 1'b0;
                n_sname_en    = 1'b0;
                n_last_code   = 8'd0;
                n_overrun     = 1'b0;
            end else begin
                next_on  = (i_in.region == REGION_OPTIONS) ? n_file_en : n_sname_en;
                n_phase  = (n_magic_good && next_on) ? PH_CODE : PH_SKIP;
                n_remain = 8'd0;
                n_pos    = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MAGIC;
            r_magic_count <= 2'd0;
            r_magic_good  <= 1'b1;
            r_code        <= 8'd0;
            r_remain      <= 8'd0;
            r_pos         <= 8'd0;
            r_file_en     <= 1'b0;
            r_sname_en    <= 1'b0;
            r_last_code   <= 8'd0;
            r_overrun     <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_magic_count <= n_magic_count;
            r_magic_good  <= n_magic_good;
            r_code        <= n_code;
            r_remain      <= n_remain;
            r_pos         <= n_pos;
            r_file_en     <= n_file_en;
            r_sname_en    <= n_sname_en;
            r_last_code   <= n_last_code;
            r_overrun     <= n_overrun;
        end
    end

    // option result goes ahead of the done result
    always_comb begin
        if (!accept) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = {1'b0, res_opt} + {1'b0, res_done};
        end
    end

    dhcpop_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_data_a   (res_opt ? opt_result : done_result),
        .i_data_b   (done_result),
        .i_pop      (o_out.valid & o_out.ready),
        .o_head     (fifo_head),
        .o_status   (fifo_status),
        .o_level    (fifo_level)
    );

    assign i_in.ready           = fifo_status.room_two;
    assign o_out.valid          = fifo_status.not_empty;
    assign o_out.kind           = fifo_head.kind;
    assign o_out.option_code    = fifo_head.option_code;
    assign o_out.byte_index     = fifo_head.byte_index;
    assign o_out.value          = fifo_head.value;
    assign o_out.last_of_option = fifo_head.last_of_option;
    assign o_out.end_found      = fifo_head.end_found;
    assign o_out.truncated      = fifo_head.truncated;
    assign o_out.magic_ok       = fifo_head.magic_ok;

    // queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_level <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    // a cookie phase with nothing counted yet starts with the cookie marked good
    a_magic_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MAGIC && r_magic_count == 2'd0 |-> r_magic_good)
        else $error("fresh cookie phase with cookie already bad");

    // data phase always has bytes left to take
    a_data_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remain != 8'd0)
        else $error("data phase with zero bytes remaining");

    // end of server-name region restarts the parse
    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_in_region && i_in.region[1]
        |=> r_phase == PH_MAGIC && r_magic_good && !r_overrun)
        else $error("parser not restarted after done");

endmodule

// ===== tb/dhcp_option_parser_test.sv =====
`timescale 1ns / 1ps

module dhcp_option_parser_test;
    import dhcpop_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_PCT     = 7;
    localparam int QUIET_START  = 250;    // stretch with no idling on either side
    localparam int QUIET_STOP   = 550;
    localparam int DRAIN_EVERY  = 12;     // every Nth message waits for the pipe to empty
    localparam int TARGET_ITEMS = 740;

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        logic [1:0] region;
        logic [7:0] data_byte;
        logic       last;
        bit         drain;      // hold off until every expected result is back
    } t_request;

    // parser walk state, mirrors the block
    typedef enum logic [2:0] {
        SCAN_COOKIE,
        SCAN_CODE,
        SCAN_LEN,
        SCAN_DATA,
        SCAN_SKIP
    } t_scan;

    logic i_clk;
    logic i_rst_n;

    dhcpop_in_if  in_if ();
    dhcpop_out_if out_if ();

    dhcp_option_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_request   request_q[$];
    t_result    option_q[$];     // results still owed by the parser
    int         cycle_cnt;
    int         mismatch_cnt;
    bit         drain_next;
    logic       quiet;

    // predicted parser state
    t_scan      scan;
    logic [1:0] cookie_cnt;
    logic       cookie_good;
    logic [7:0] cur_code;
    logic [7:0] remaining;
    logic [7:0] position;
    logic       file_on;
    logic       sname_on;
    logic [7:0] last_code;
    logic       overrun;

    assign quiet = (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_STOP);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result make_result(logic [1:0] kind, logic [7:0] code,
                                            logic [7:0] idx, logic [7:0] val,
                                            logic lst, logic endf, logic trunc,
                                            logic mok);
        t_result r;
        r.kind           = kind;
        r.option_code    = code;
        r.byte_index     = idx;
        r.value          = val;
        r.last_of_option = lst;
        r.end_found      = endf;
        r.truncated      = trunc;
        r.magic_ok       = mok;
        return r;
    endfunction

    task automatic clear_parse_state();
        scan        = SCAN_COOKIE;
        cookie_cnt  = 2'd0;
        cookie_good = 1'b1;
        cur_code    = 8'd0;
        remaining   = 8'd0;
        position    = 8'd0;
        file_on     = 1'b0;
        sname_on    = 1'b0;
        last_code   = 8'd0;
        overrun     = 1'b0;
    endtask

    // One accepted byte: advance the walk and queue whatever it yields.
    task automatic parse_byte(input logic [1:0] rgn, input logic [7:0] b, input logic lst);
        logic next_on;
        case (scan)
            SCAN_COOKIE: begin
                if (b != MAGIC_COOKIE[8 * (3 - cookie_cnt) +: 8])
                    cookie_good = 1'b0;
                cookie_cnt = cookie_cnt + 2'd1;
                if (cookie_cnt == 2'd0)
                    scan = cookie_good ? SCAN_CODE : SCAN_SKIP;
                else if (lst)
                    cookie_good = 1'b0;   // region ended inside the cookie
            end
            SCAN_CODE: begin
                last_code = b;
                if (b == OPT_END) begin
                    scan = SCAN_SKIP;
                end else if (b != OPT_PAD) begin
                    cur_code = b;
                    scan     = SCAN_LEN;
                end
            end
            SCAN_LEN: begin
                remaining = b;
                position  = 8'd0;
                if (b == 8'd0) begin
                    if (cur_code != OPT_OVERLOAD)
                        option_q.push_back(make_result(KIND_EMPTY, cur_code, 8'd0, 8'd0,
                                                       1'b1, 1'b0, 1'b0, 1'b0));
                    scan = SCAN_CODE;
                end else begin
                    scan = SCAN_DATA;
                end
            end
            SCAN_DATA: begin
                if (cur_code == OPT_OVERLOAD) begin
                    if (position == 8'd0) begin
                        file_on  = b[0];
                        sname_on = b[1];
                    end
                end else begin
                    option_q.push_back(make_result(KIND_DATA, cur_code, position, b,
                                                   remaining == 8'd1, 1'b0, 1'b0, 1'b0));
                end
                position  = position + 8'd1;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                    scan = SCAN_CODE;
            end
            default: begin
            end
        endcase

        if (lst) begin
            if (scan == SCAN_LEN || scan == SCAN_DATA)
                overrun = 1'b1;
            if (rgn >= REGION_SNAME) begin
                option_q.push_back(make_result(KIND_DONE, last_code, 8'd0, 8'd0, 1'b0,
                                               last_code == OPT_END, overrun, cookie_good));
                clear_parse_state();
            end else begin
                // enable for the next region is frozen here
                next_on   = (rgn == REGION_OPTIONS) ? file_on : sname_on;
                scan      = (cookie_good && next_on) ? SCAN_CODE : SCAN_SKIP;
                remaining = 8'd0;
                position  = 8'd0;
            end
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic push_byte(input logic [1:0] rgn, input logic [7:0] b, input logic lst);
        t_request r;
        r.region    = rgn;
        r.data_byte = b;
        r.last      = lst;
        r.drain     = drain_next;
        drain_next  = 1'b0;
        request_q.push_back(r);
    endtask

    // Region field only matters on the final byte; scramble it elsewhere now and then.
    task automatic push_region(input logic [1:0] rgn, ref t_byte_q bytes);
        logic [1:0] r;
        for (int i = 0; i < bytes.size(); i++) begin
            if (i == bytes.size() - 1)
                r = rgn;
            else
                r = ($urandom_range(99) < 12) ? 2'($urandom_range(3)) : rgn;
            push_byte(r, bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic add_option(ref t_byte_q q, input logic [7:0] code, input int len);
        q.push_back(code);
        q.push_back(8'(len));
        for (int i = 0; i < len; i++)
            q.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_options(ref t_byte_q q, input int n);
        int k;
        int len;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 8) begin
                q.push_back(OPT_PAD);
            end else if (k < 13) begin
                add_option(q, OPT_OVERLOAD, $urandom_range(2));
            end else begin
                k = $urandom_range(99);
                if (k < 20)
                    len = 0;
                else if (k < 95)
                    len = $urandom_range(6, 1);
                else
                    len = $urandom_range(30, 7);
                add_option(q, 8'($urandom_range(254, 1)), len);
            end
        end
    endtask

    // Region end: END plus skipped filler, a cut-off option, or nothing.
    task automatic add_tail(ref t_byte_q q);
        int k;
        int len;
        k = $urandom_range(99);
        if (k < 40) begin
            q.push_back(OPT_END);
            repeat ($urandom_range(3)) q.push_back(8'($urandom_range(255)));
        end else if (k < 58) begin
            q.push_back(8'($urandom_range(254, 1)));
            if ($urandom_range(1)) begin
                len = $urandom_range(10, 1);
                q.push_back(8'(len));
                repeat ($urandom_range(len - 1)) q.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic build_message(input bit big);
        t_byte_q    opts;
        t_byte_q    file_b;
        t_byte_q    sname_b;
        int         k;
        logic [1:0] sname_rgn;
        k = $urandom_range(99);
        if (k < 6) begin
            // options region ends inside the cookie
            for (int i = 0; i < $urandom_range(3, 1); i++)
                opts.push_back(MAGIC_COOKIE[8 * (3 - i) +: 8]);
        end else begin
            for (int i = 0; i < 4; i++)
                opts.push_back(MAGIC_COOKIE[8 * (3 - i) +: 8]);
            if (k < 13)
                opts[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
            if ($urandom_range(99) < 75)
                add_option(opts, OPT_OVERLOAD, ($urandom_range(9) == 0) ? 0 :
                           $urandom_range(2, 1));
            add_options(opts, $urandom_range(5));
            if (big)
                add_option(opts, 8'($urandom_range(254, 53)), 255);
            add_tail(opts);
        end
        push_region(REGION_OPTIONS, opts);

        add_options(file_b, $urandom_range(3));
        add_tail(file_b);
        if (file_b.size() == 0)
            file_b.push_back(OPT_PAD);
        push_region(REGION_FILE, file_b);

        add_options(sname_b, $urandom_range(3));
        add_tail(sname_b);
        if (sname_b.size() == 0)
            sname_b.push_back(OPT_PAD);
        sname_rgn = ($urandom_range(9) == 0) ? 2'd3 : REGION_SNAME;
        push_region(sname_rgn, sname_b);
    endtask

    task automatic build_directed();
        // cookie carrying odd region values, then empty option, extreme code and value,
        // overload enabling both regions, END with a skipped byte after it
        push_byte(REGION_SNAME, 8'h63, 1'b0);
        push_byte(2'd3, 8'h82, 1'b0);
        push_byte(REGION_OPTIONS, 8'h53, 1'b0);
        push_byte(REGION_OPTIONS, 8'h63, 1'b0);
        push_byte(REGION_OPTIONS, OPT_PAD, 1'b0);
        push_byte(REGION_OPTIONS, 8'h01, 1'b0);
        push_byte(REGION_OPTIONS, 8'h00, 1'b0);
        push_byte(REGION_OPTIONS, 8'hFE, 1'b0);
        push_byte(REGION_OPTIONS, 8'h01, 1'b0);
        push_byte(REGION_OPTIONS, 8'hFF, 1'b0);
        push_byte(REGION_OPTIONS, OPT_OVERLOAD, 1'b0);
        push_byte(REGION_OPTIONS, 8'h01, 1'b0);
        push_byte(REGION_OPTIONS, 8'h03, 1'b0);
        push_byte(REGION_OPTIONS, OPT_END, 1'b0);
        push_byte(REGION_OPTIONS, 8'h2A, 1'b1);
        // file: option finishing exactly on the region end
        push_byte(REGION_FILE, 8'h0C, 1'b0);
        push_byte(REGION_FILE, 8'h01, 1'b0);
        push_byte(REGION_FILE, 8'h00, 1'b1);
        // server name: option overruns the region
        push_byte(REGION_SNAME, 8'h0F, 1'b0);
        push_byte(REGION_SNAME, 8'h02, 1'b0);
        push_byte(REGION_SNAME, 8'hAA, 1'b1);

        // options region too short for the cookie, region value three ends it
        push_byte(REGION_OPTIONS, 8'h63, 1'b0);
        push_byte(REGION_OPTIONS, 8'h82, 1'b1);
        push_byte(REGION_FILE, 8'h01, 1'b1);
        push_byte(2'd3, OPT_END, 1'b1);

        // zero-length overload, plain empty option, END as the last code
        for (int i = 0; i < 4; i++)
            push_byte(REGION_OPTIONS, MAGIC_COOKIE[8 * (3 - i) +: 8], 1'b0);
        push_byte(REGION_OPTIONS, OPT_OVERLOAD, 1'b0);
        push_byte(REGION_OPTIONS, 8'h00, 1'b0);
        push_byte(REGION_OPTIONS, 8'h05, 1'b0);
        push_byte(REGION_OPTIONS, 8'h00, 1'b0);
        push_byte(REGION_OPTIONS, OPT_END, 1'b1);
        push_byte(REGION_FILE, OPT_PAD, 1'b1);
        push_byte(REGION_SNAME, OPT_PAD, 1'b1);
    endtask

    // ---------------- sequencing ----------------

    initial begin
        int msg;
        in_if.valid          = 1'b0;
        in_if.region         = 2'd0;
        in_if.data_byte      = 8'd0;
        in_if.last_in_region = 1'b0;
        out_if.ready         = 1'b0;
        i_rst_n              = 1'b0;
        mismatch_cnt         = 0;
        drain_next           = 1'b0;
        clear_parse_state();

        build_directed();
        msg = 0;
        while (request_q.size() < TARGET_ITEMS) begin
            if (msg % DRAIN_EVERY == 0)
                drain_next = 1'b1;
            if ($urandom_range(99) < 8) begin
                // noise: random bytes, region codes and region ends
                repeat ($urandom_range(15, 3))
                    push_byte(2'($urandom_range(3)), 8'($urandom_range(255)),
                              $urandom_range(3) == 0);
            end else begin
                build_message(msg == 5);
            end
            msg++;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (option_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_cnt == 0 && option_q.size() == 0) begin
            $display("dhcp_option_parser_test: PASS");
        end else begin
            $display("dhcp_option_parser_test: FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("dhcp_option_parser_test: FAIL");
            $finish;
        end
    end

    initial cycle_cnt = 0;

    // Driver: hold a request until taken, then maybe idle, then offer the next one.
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        bit       go;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            go = request_q.size() != 0;
            if (go && request_q[0].drain)
                go = !in_if.valid && option_q.size() == 0;
            if (go && !quiet && $urandom_range(99) < IDLE_PCT)
                go = 1'b0;
            if (go) begin
                nxt = request_q.pop_front();
                in_if.valid          <= 1'b1;
                in_if.region         <= nxt.region;
                in_if.data_byte      <= nxt.data_byte;
                in_if.last_in_region <= nxt.last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on every taken request, check every taken result.
    always @(posedge i_clk) begin : watch_results
        t_result got;
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                parse_byte(in_if.region, in_if.data_byte, in_if.last_in_region);

            if (out_if.valid && out_if.ready) begin
                got = make_result(out_if.kind, out_if.option_code, out_if.byte_index,
                                  out_if.value, out_if.last_of_option, out_if.end_found,
                                  out_if.truncated, out_if.magic_ok);
                if (option_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("cycle %0d: unexpected result kind %0d code %02h idx %0d",
                                 cycle_cnt, got.kind, got.option_code, got.byte_index);
                end else begin
                    want = option_q.pop_front();
                    bad = (got.kind !== want.kind)
                       || (got.option_code !== want.option_code)
                       || (got.byte_index !== want.byte_index)
                       || (got.value !== want.value)
                       || (got.last_of_option !== want.last_of_option)
                       || (got.end_found !== want.end_found)
                       || (got.truncated !== want.truncated)
                       || (got.magic_ok !== want.magic_ok);
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("cycle %0d: expected k%0d c%02h i%0d v%02h l%0d e%0d t%0d m%0d",
                                   cycle_cnt, want.kind, want.option_code,
                                   want.byte_index, want.value, want.last_of_option,
                                   want.end_found, want.truncated, want.magic_ok);
                            $display(" got k%0d c%02h i%0d v%02h l%0d e%0d t%0d m%0d",
                                     got.kind, got.option_code, got.byte_index, got.value,
                                     got.last_of_option, got.end_found, got.truncated,
                                     got.magic_ok);
                        end
                    end
                end
            end

            out_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

endmodule

// ===== filelist.f =====
src/dhcpop_pkg.sv
src/dhcpop_if.sv
src/dhcpop_out_fifo.sv
src/dhcp_option_parser.sv
tb/dhcp_option_parser_test.sv
